// ----- design/rasc_pkg.sv -----
// shared types, constants and tables of the rotate-add stream cipher
package rasc_pkg;

    localparam int KS_BYTES   = 64;
    localparam int KS_WORDS   = KS_BYTES / 4;
    localparam int WORD_W     = 32;
    localparam int POS_W      = $clog2(KS_BYTES) + 1;
    localparam int WIDX_W     = $clog2(KS_WORDS);
    localparam int ROUNDS     = 10;
    localparam int STEPS      = 8;
    localparam int STEP_W     = $clog2(STEPS);
    localparam int ROUND_W    = $clog2(ROUNDS);
    localparam int ROT_W      = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    typedef logic [WORD_W-1:0] t_word;

    localparam t_word CONST_W4 = 32'hf607_8754;
    localparam t_word CONST_W5 = 32'h3502_4727;
    localparam t_word CONST_W6 = 32'h0796_3435;
    localparam t_word CONST_W7 = 32'he227_5686;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_OUT
    } t_state;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_0     = 3'd0,
        CFG_KEY_1     = 3'd1,
        CFG_KEY_2     = 3'd2,
        CFG_KEY_3     = 3'd3,
        CFG_NONCE_LO  = 3'd4,
        CFG_NONCE_HI  = 3'd5,
        CFG_START_CTR = 3'd6
    } t_cfg_idx;

    // left rotation of the 128-bit group for each step of a round
    function automatic logic [ROT_W-1:0] rot_amount(input logic [STEP_W-1:0] step);
        logic [ROT_W-1:0] amt;
        case (step)
            3'd0:    amt = 7'd17;
            3'd1:    amt = 7'd23;
            3'd2:    amt = 7'd71;
            3'd3:    amt = 7'd73;
            3'd4:    amt = 7'd41;
            3'd5:    amt = 7'd53;
            3'd6:    amt = 7'd31;
            3'd7:    amt = 7'd47;
            default: amt = 7'd0;
        endcase
        return amt;
    endfunction

endpackage

// ----- design/rotate_add_stream_cipher_unit.sv -----
// top level of the rotate-add stream cipher: byte stream in, keystream-xored byte stream out
//
// Each byte taken on the slave side leaves on the master side xored with the next byte
// of a 64-byte keystream block. A block is made from the counter, the 96-bit nonce, four
// constants and the 256-bit key by ten rounds of eight rotate-add steps, all done by one
// shared unit (a 128-bit rotator and four 32-bit adders) at one step per clock. The
// sixteen working words sit in a register ring: each step turns the ring so that the
// next group of its kind (diagonal or column) lies on the same four taps, and after the
// last step the ring holds the finished block in order, which then serves as the
// keystream buffer. A byte that finds keystream left is xored and registered on accept;
// one needing a fresh block (buffer empty, restart set, or first byte after a call end)
// waits through the block's steps, no byte being taken meanwhile. A next byte is taken
// only while the output register is empty or being emptied. Key, nonce and start counter
// are written on the config port while the block is idle, a rule the user keeps as it is
// unchecked here; key and nonce apply at the next block, the start counter at a restart.
module rotate_add_stream_cipher_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // config write port
    input  logic                                i_cfg_wr_en,
    input  logic [rasc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rasc_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    // input words
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,   // [7:0] in_byte
    input  logic                                s_axis_tuser,   // [0] restart
    input  logic                                s_axis_tlast,   // call_end
    // output words
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [7:0]                          m_axis_tdata    // [7:0] out_byte
);
    import rasc_pkg::*;

    // config registers
    logic [CFG_DATA_W-1:0] r_key [4];
    logic [63:0]           r_nonce_lo;
    t_word                 r_nonce_hi;
    t_word                 r_start;

    // control state
    t_state               r_state, n_state;
    t_word                r_counter, n_counter;
    logic [POS_W-1:0]     r_pos, n_pos;         // top bit set: buffer empty
    logic [STEP_W-1:0]    r_step, n_step;
    logic [ROUND_W-1:0]   r_round, n_round;
    logic                 r_out_valid, n_out_valid;

    // payload
    t_word                r_v [KS_WORDS];       // working ring, later keystream buffer
    t_word                n_v [KS_WORDS];
    logic [7:0]           r_byte, n_byte;
    logic                 r_last, n_last;
    logic [7:0]           r_out_data, n_out_data;

    // shared rotate-add unit
    logic                 diag;
    t_word                ta, tb, tc, td;
    logic [127:0]         grp;
    logic [255:0]         grp_dbl;
    logic [127:0]         grp_rot;
    t_word                u [KS_WORDS];
    logic [WIDX_W-1:0]    turn;

    // keystream byte at the current position
    t_word                ks_word;
    logic [7:0]           ks_byte;

    logic                 out_free;
    logic                 need_block;
    t_word                ctr_sel;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign out_free = !r_out_valid || m_axis_tready;

    assign ks_word = r_v[r_pos[WIDX_W+1:2]];
    assign ks_byte = 8'(ks_word >> {r_pos[1:0], 3'b000});

    // diagonal steps use taps 0,5,10,15 and turn the ring by four words; column steps
    // use taps 0,4,8,12 and turn by one, the last one by thirteen to realign the ring
    assign diag = !r_step[2];
    assign ta   = r_v[0];
    assign tb   = diag ? r_v[5]  : r_v[4];
    assign tc   = diag ? r_v[10] : r_v[8];
    assign td   = diag ? r_v[15] : r_v[12];

    assign grp     = {ta, tb, tc, td};
    assign grp_dbl = {grp, grp} << rot_amount(r_step);
    assign grp_rot = grp_dbl[255:128];

    always_comb begin
        for (int i = 0; i < KS_WORDS; i++) begin
            u[i] = r_v[i];
        end
        u[0] = ta + grp_rot[127:96];
        if (diag) begin
            u[5]  = tb + grp_rot[95:64];
            u[10] = tc + grp_rot[63:32];
            u[15] = td + grp_rot[31:0];
        end else begin
            u[4]  = tb + grp_rot[95:64];
            u[8]  = tc + grp_rot[63:32];
            u[12] = td + grp_rot[31:0];
        end
    end

    always_comb begin
        if (diag) begin
            turn = WIDX_W'(4);
        end else if (r_step == STEP_W'(STEPS - 1)) begin
            turn = WIDX_W'(13);
        end else begin
            turn = WIDX_W'(1);
        end
    end

    assign need_block = s_axis_tuser || r_pos[POS_W-1];
    assign ctr_sel    = s_axis_tuser ? r_start : r_counter;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_counter   = r_counter;
        n_pos       = r_pos;
        n_step      = r_step;
        n_round     = r_round;
        n_out_valid = r_out_valid;
        n_byte      = r_byte;
        n_last      = r_last;
        n_out_data  = r_out_data;
        for (int i = 0; i < KS_WORDS; i++) begin
            n_v[i] = r_v[i];
        end
        s_axis_tready = 1'b0;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                s_axis_tready = out_free;
                if (s_axis_tvalid && out_free) begin
                    if (need_block) begin
                        // load the initial state, counter reloaded on restart
                        n_counter = ctr_sel;
                        n_v[0]    = ctr_sel;
                        n_v[1]    = r_nonce_lo[31:0];
                        n_v[2]    = r_nonce_lo[63:32];
                        n_v[3]    = r_nonce_hi;
                        n_v[4]    = CONST_W4;
                        n_v[5]    = CONST_W5;
                        n_v[6]    = CONST_W6;
                        n_v[7]    = CONST_W7;
                        for (int k = 0; k < 4; k++) begin
                            n_v[8 + 2 * k] = r_key[k][31:0];
                            n_v[9 + 2 * k] = r_key[k][63:32];
                        end
                        n_byte  = s_axis_tdata;
                        n_last  = s_axis_tlast;
                        n_step  = '0;
                        n_round = '0;
                        n_state = ST_ROUND;
                    end else begin
                        n_out_valid = 1'b1;
                        n_out_data  = s_axis_tdata ^ ks_byte;
                        n_pos       = s_axis_tlast ? POS_W'(KS_BYTES) : r_pos + 1'b1;
                    end
                end
            end
            ST_ROUND: begin
                // one rotate-add step, then turn the ring
                for (int i = 0; i < KS_WORDS; i++) begin
                    n_v[i] = u[WIDX_W'(i) + turn];
                end
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(STEPS - 1)) begin
                    n_round = r_round + 1'b1;
                    if (r_round == ROUND_W'(ROUNDS - 1)) begin
                        n_counter = r_counter + 1'b1;
                        n_pos     = '0;
                        n_state   = ST_OUT;
                    end
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_byte ^ ks_byte;
                    n_pos       = r_last ? POS_W'(KS_BYTES) : r_pos + 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter   <= '0;
            r_pos       <= POS_W'(KS_BYTES);
            r_step      <= '0;
            r_round     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_counter   <= n_counter;
            r_pos       <= n_pos;
            r_step      <= n_step;
            r_round     <= n_round;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < KS_WORDS; i++) begin
            r_v[i] <= n_v[i];
        end
        r_byte     <= n_byte;
        r_last     <= n_last;
        r_out_data <= n_out_data;
    end

    // config writes, unknown index ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_key[k] <= '0;
            end
            r_nonce_lo <= '0;
            r_nonce_hi <= '0;
            r_start    <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_KEY_0:     r_key[0]   <= i_cfg_wdata;
                CFG_KEY_1:     r_key[1]   <= i_cfg_wdata;
                CFG_KEY_2:     r_key[2]   <= i_cfg_wdata;
                CFG_KEY_3:     r_key[3]   <= i_cfg_wdata;
                CFG_NONCE_LO:  r_nonce_lo <= i_cfg_wdata;
                CFG_NONCE_HI:  r_nonce_hi <= i_cfg_wdata[WORD_W-1:0];
                CFG_START_CTR: r_start    <= i_cfg_wdata[WORD_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

// ----- tb/tb_rotate_add_stream_cipher_unit.sv -----
// self-checking testbench of the rotate-add stream cipher unit: directed and random byte streams
module tb_rotate_add_stream_cipher_unit;

    import rasc_pkg::*;

    // index beyond the last register, writes to it must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;
    localparam int CLK_HALF    = 6;
    localparam int RST_CYCLES  = 11;
    localparam int SETTLE_CYC  = 4;
    localparam int MAX_REPORTS = 10;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = '0;   // [7:0] in_byte
    logic                  s_axis_tuser = 1'b0; // [0] restart
    logic                  s_axis_tlast = 1'b0; // call_end
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [7:0]            m_axis_tdata;        // [7:0] out_byte

    rotate_add_stream_cipher_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // cipher predictor: own copy of the registers and keystream state
    // ------------------------------------------------------------------
    logic [63:0] cfg_key [4];
    logic [63:0] cfg_nonce_lo;
    t_word       cfg_nonce_hi;
    t_word       cfg_start;
    t_word       ks_counter;
    t_word       ks_words [KS_WORDS];
    int          ks_pos;

    logic [7:0]  cipher_bytes_due [$];
    int          mismatch_count;

    // rotate the 128-bit group {a,b,c,d} left and add it back, word by word
    function automatic void mix_group(input int a, input int b, input int c, input int d,
                                      input int amount);
        logic [127:0] grp;
        logic [127:0] rot;
        grp = {ks_words[a], ks_words[b], ks_words[c], ks_words[d]};
        rot = (grp << amount) | (grp >> (128 - amount));
        ks_words[a] = ks_words[a] + rot[127:96];
        ks_words[b] = ks_words[b] + rot[95:64];
        ks_words[c] = ks_words[c] + rot[63:32];
        ks_words[d] = ks_words[d] + rot[31:0];
    endfunction

    // build a fresh 64-byte block from counter, nonce, constants and key
    function automatic void refill_keystream();
        int r;
        int k;
        ks_words[0] = ks_counter;
        ks_words[1] = cfg_nonce_lo[31:0];
        ks_words[2] = cfg_nonce_lo[63:32];
        ks_words[3] = cfg_nonce_hi;
        ks_words[4] = CONST_W4;
        ks_words[5] = CONST_W5;
        ks_words[6] = CONST_W6;
        ks_words[7] = CONST_W7;
        for (k = 0; k < 4; k++) begin
            ks_words[8 + 2*k] = cfg_key[k][31:0];
            ks_words[9 + 2*k] = cfg_key[k][63:32];
        end
        // diagonals then columns, fixed rotation per step
        for (r = 0; r < ROUNDS; r++) begin
            mix_group(0, 5, 10, 15, 17);
            mix_group(4, 9, 14, 3, 23);
            mix_group(8, 13, 2, 7, 71);
            mix_group(12, 1, 6, 11, 73);
            mix_group(0, 4, 8, 12, 41);
            mix_group(1, 5, 9, 13, 53);
            mix_group(2, 6, 10, 14, 31);
            mix_group(3, 7, 11, 15, 47);
        end
        ks_counter = ks_counter + 32'd1;   // wraps at 32 bits
        ks_pos     = 0;
    endfunction

    // expected output byte for one accepted word, advancing the keystream
    function automatic logic [7:0] cipher_byte(input logic [7:0] din, input logic restart,
                                               input logic call_end);
        logic [7:0] ks;
        if (restart) begin
            ks_counter = cfg_start;
            ks_pos     = KS_BYTES;
        end
        if (ks_pos >= KS_BYTES)
            refill_keystream();
        ks = 8'(ks_words[ks_pos / 4] >> (8 * (ks_pos % 4)));
        ks_pos = ks_pos + 1;
        // end of a call throws away what is left of the block
        if (call_end)
            ks_pos = KS_BYTES;
        return din ^ ks;
    endfunction

    // ------------------------------------------------------------------
    // idling on both sides
    // ------------------------------------------------------------------
    bit gaps_on  = 1'b1;
    bit stalls_on = 1'b1;
    int stall_left = 0;

    // mostly short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 12);
        else
            return $urandom_range(30, 100);
    endfunction

    // receiver back-pressure
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left = stall_left - 1;
        end else if (stalls_on && $urandom_range(0, 99) < 30) begin
            m_axis_tready <= 1'b0;
            stall_left = idle_len() - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // result checker: every output word against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        logic [7:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (cipher_bytes_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected output word: out_byte 0x%02h", m_axis_tdata);
            end else begin
                want = cipher_bytes_due.pop_front();
                if (m_axis_tdata !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("out_byte mismatch: expected 0x%02h, got 0x%02h",
                                 want, m_axis_tdata);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // shared drivers
    // ------------------------------------------------------------------

    // one word on the slave side, optionally after an idle gap
    task automatic send_byte(input logic [7:0] din, input logic restart,
                             input logic call_end);
        int gap;
        gap = (gaps_on && $urandom_range(0, 99) < 40) ? idle_len() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= din;
        s_axis_tuser  <= restart;
        s_axis_tlast  <= call_end;
        do @(posedge i_clk); while (!s_axis_tready);
        cipher_bytes_due.push_back(cipher_byte(din, restart, call_end));
    endtask

    // register write, mirrored into the predictor
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_KEY_0:     cfg_key[0]   = val;
            CFG_KEY_1:     cfg_key[1]   = val;
            CFG_KEY_2:     cfg_key[2]   = val;
            CFG_KEY_3:     cfg_key[3]   = val;
            CFG_NONCE_LO:  cfg_nonce_lo = val;
            CFG_NONCE_HI:  cfg_nonce_hi = val[31:0];
            CFG_START_CTR: cfg_start    = val[31:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // drop valid and wait until every expected word has come back
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (cipher_bytes_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // registers at reset, counter 0, no restart needed
    task automatic test_reset_key();
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hff, 1'b0, 1'b0);
        send_byte(8'h55, 1'b0, 1'b0);
        send_byte(8'haa, 1'b0, 1'b1);
        settle();
    endtask

    // all-ones registers, width masking, unused index, counter wrap,
    // restart and call end on one word
    task automatic test_extremes_and_wrap();
        cfg_write(CFG_KEY_0, '1);
        cfg_write(CFG_KEY_1, '1);
        cfg_write(CFG_KEY_2, '1);
        cfg_write(CFG_KEY_3, '1);
        cfg_write(CFG_NONCE_LO, '1);
        cfg_write(CFG_NONCE_HI, 64'hdead_beef_ffff_ffff);
        cfg_write(CFG_START_CTR, 64'h1234_5678_ffff_ffff);
        cfg_write(CFG_IDX_UNUSED, rand64());
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'hff, 1'b0, 1'b1);
        send_byte(8'h80, 1'b0, 1'b1);   // next block, counter wrapped to 0
        send_byte(8'h01, 1'b1, 1'b1);
        send_byte(8'h02, 1'b0, 1'b0);
        settle();
    endtask

    // a key change must wait for the next block
    task automatic test_key_change_mid_block();
        send_byte(8'h10, 1'b1, 1'b0);
        send_byte(8'h20, 1'b0, 1'b0);
        settle();
        cfg_write(CFG_KEY_2, rand64());
        send_byte(8'h30, 1'b0, 1'b0);
        send_byte(8'h40, 1'b0, 1'b1);
        send_byte(8'h50, 1'b0, 1'b0);
        settle();
    endtask

    // each register on its own, one fresh block per write
    task automatic test_each_register();
        int k;
        for (k = 0; k <= CFG_START_CTR; k++) begin
            cfg_write(k[CFG_IDX_W-1:0], rand64());
            send_byte(8'($urandom), 1'b1, 1'b1);
            settle();
        end
    endtask

    // calls of random length with random content
    task automatic run_calls(input int n_items);
        int sent;
        int len;
        int r;
        int k;
        logic restart;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 50)
                len = $urandom_range(1, 16);
            else if (r < 85)
                len = $urandom_range(17, 70);
            else
                len = $urandom_range(60, 200);   // crosses block boundaries
            for (k = 0; k < len && sent < n_items; k++) begin
                if (k == 0)
                    restart = ($urandom_range(0, 99) < 35);
                else
                    restart = ($urandom_range(0, 199) == 0);
                send_byte(8'($urandom), restart, k == len - 1);
                sent++;
            end
        end
    endtask

    // phases of random settings, extremes among them
    task automatic test_random_streams();
        int ph;
        int k;
        for (ph = 0; ph < 10; ph++) begin
            gaps_on   = (ph % 4 != 1);
            stalls_on = (ph % 4 != 1);
            for (k = 0; k <= CFG_START_CTR; k++) begin
                if (ph == 3)
                    cfg_write(k[CFG_IDX_W-1:0], '1);
                else if (ph == 6)
                    cfg_write(k[CFG_IDX_W-1:0], '0);
                else if (ph == 0 || $urandom_range(0, 1) == 1)
                    cfg_write(k[CFG_IDX_W-1:0], rand64());
            end
            // start just below the wrap now and then
            if (ph % 3 == 2)
                cfg_write(CFG_START_CTR, 64'hffff_ffff - $urandom_range(0, 3));
            if ($urandom_range(0, 2) == 0)
                cfg_write(CFG_IDX_UNUSED, rand64());
            run_calls(160);
            settle();
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        cfg_key        = '{default: '0};
        cfg_nonce_lo   = '0;
        cfg_nonce_hi   = '0;
        cfg_start      = '0;
        ks_counter     = '0;
        ks_words       = '{default: '0};
        ks_pos         = KS_BYTES;
        mismatch_count = 0;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_key();
        test_extremes_and_wrap();
        test_key_change_mid_block();
        test_each_register();
        test_random_streams();

        if (mismatch_count == 0)
            $display("tb_rotate_add_stream_cipher_unit: done, clean");
        else
            $display("tb_rotate_add_stream_cipher_unit: done, errors");
        $finish;
    end

    // watchdog
    initial begin
        #(2 * CLK_HALF * 6_000_000);
        $display("tb_rotate_add_stream_cipher_unit: done, errors");
        $finish;
    end

endmodule

// ----- rotate_add_stream_cipher_unit.f -----
design/rasc_pkg.sv
design/rotate_add_stream_cipher_unit.sv
tb/tb_rotate_add_stream_cipher_unit.sv
